FILE: rtl/lcdt_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package lcdt_pkg;

  localparam int unsigned AccW     = 16;
  localparam int unsigned LineW    = 8;
  localparam int unsigned CycW     = 8;
  localparam int unsigned CfgIdxW  = 1;
  localparam int unsigned CfgDataW = 8;

  // mode thresholds and frame geometry
  localparam int unsigned HblankEnd   = 207;
  localparam int unsigned SearchEnd   = 83;
  localparam int unsigned TransferEnd = 175;
  localparam int unsigned FrameCycles = 4560;

  localparam logic [AccW:0]    VblankLine      = 17'd465;
  localparam logic [LineW-1:0] FirstVblankLine = 8'd144;
  localparam logic [LineW-1:0] LastLine        = 8'd153;

  typedef enum logic [1:0] {
    MODE_HBLANK   = 2'd0,
    MODE_VBLANK   = 2'd1,
    MODE_SEARCH   = 2'd2,
    MODE_TRANSFER = 2'd3
  } mode_e;

  typedef enum logic [CfgIdxW-1:0] {
    REG_LCD_ENABLE   = 1'b0,
    REG_LINE_COMPARE = 1'b1
  } reg_idx_e;

  typedef struct packed {
    mode_e             mode;
    logic [LineW-1:0]  line;
    logic [AccW-1:0]   accum;
    logic              coin;
  } state_t;

  typedef struct packed {
    mode_e             mode;
    logic [LineW-1:0]  line;
    logic              coincidence;
    logic              vblank_irq;
    logic              compare_irq;
    logic              draw_line;
    logic [LineW-1:0]  drawn_line;
    logic              sprite_scan;
    logic              tile_decode;
    logic              frame_done;
  } result_t;

endpackage

`default_nettype wire

FILE: rtl/lcdt_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface lcdt_req_if;
  logic       valid;
  logic       ready;
  logic [7:0] elapsed_cycles;

  modport source (output valid, output elapsed_cycles, input ready);
  modport sink   (input valid, input elapsed_cycles, output ready);
endinterface

interface lcdt_rsp_if;
  logic       valid;
  logic       ready;
  logic [1:0] mode;
  logic [7:0] line;
  logic       coincidence;
  logic       vblank_irq;
  logic       compare_irq;
  logic       draw_line;
  logic [7:0] drawn_line;
  logic       sprite_scan;
  logic       tile_decode;
  logic       frame_done;

  modport source (
    output valid, output mode, output line, output coincidence, output vblank_irq,
    output compare_irq, output draw_line, output drawn_line, output sprite_scan,
    output tile_decode, output frame_done, input ready
  );
  modport sink (
    input valid, input mode, input line, input coincidence, input vblank_irq,
    input compare_irq, input draw_line, input drawn_line, input sprite_scan,
    input tile_decode, input frame_done, output ready
  );
endinterface

`default_nettype wire

FILE: rtl/lcdt_modc.sv
`timescale 1ns / 1ps
`default_nettype none

module lcdt_modc
  import lcdt_pkg::*;
#(
  parameter int unsigned Divisor = HblankEnd
) (
  input  logic [AccW-1:0] value_i,
  output logic [AccW-1:0] rem_o
);

  // quotient estimate by reciprocal, low by at most one
  localparam int unsigned Shift  = AccW + 8;
  localparam int unsigned Recip  = (1 << Shift) / Divisor;
  localparam int unsigned RecipW = $clog2(Recip + 1);
  localparam int unsigned ProdW  = AccW + RecipW;
  localparam int unsigned QW     = ProdW - Shift;
  localparam logic [AccW-1:0] DivW = AccW'(Divisor);

  logic [ProdW-1:0] prod;
  logic [QW-1:0]    quot;
  logic [AccW-1:0]  back;
  logic [AccW-1:0]  rem0;

  assign prod  = ProdW'(value_i) * ProdW'(Recip);
  assign quot  = prod[ProdW-1:Shift];
  assign back  = AccW'(quot) * DivW;
  assign rem0  = value_i - back;
  assign rem_o = (rem0 >= DivW) ? (rem0 - DivW) : rem0;

endmodule

`default_nettype wire

FILE: rtl/lcdt_step.sv
`timescale 1ns / 1ps
`default_nettype none

module lcdt_step
  import lcdt_pkg::*;
(
  input  state_t            state_i,
  input  logic              enable_i,
  input  logic [LineW-1:0]  line_compare_i,
  input  logic [CycW-1:0]   cycles_i,
  output state_t            state_o,
  output result_t           result_o
);

  logic [AccW:0]      sum;
  logic [AccW-1:0]    acc;
  logic [AccW-1:0]    rem_hb;
  logic [AccW-1:0]    rem_sr;
  logic [AccW-1:0]    rem_tr;
  logic [AccW-1:0]    rem_fr;
  logic [LineW-1:0]   line_inc;
  logic [LineW-1:0]   vbl_lines;
  logic [AccW:0]      vbl_need;
  logic               vbl_adv;
  state_t             nxt;
  result_t            res;

  assign sum      = {1'b0, state_i.accum} + (AccW + 1)'(cycles_i);
  assign acc      = sum[AccW] ? '1 : sum[AccW-1:0];
  assign line_inc = state_i.line + 8'd1;

  // acc/465 + 144 > line  <=>  acc >= (line - 143) * 465 for lines from 144 up
  assign vbl_lines = state_i.line - (FirstVblankLine - 8'd1);
  assign vbl_need  = (AccW + 1)'(vbl_lines) * VblankLine;
  assign vbl_adv   = (state_i.line < FirstVblankLine) || ({1'b0, acc} >= vbl_need);

  lcdt_modc #(.Divisor(HblankEnd))   u_mod_hb (.value_i(acc), .rem_o(rem_hb));
  lcdt_modc #(.Divisor(SearchEnd))   u_mod_sr (.value_i(acc), .rem_o(rem_sr));
  lcdt_modc #(.Divisor(TransferEnd)) u_mod_tr (.value_i(acc), .rem_o(rem_tr));
  lcdt_modc #(.Divisor(FrameCycles)) u_mod_fr (.value_i(acc), .rem_o(rem_fr));

  always_comb begin
    nxt       = state_i;
    nxt.accum = acc;
    res       = '0;
    if (enable_i) begin
      case (state_i.mode)
        MODE_HBLANK: begin
          if (acc > AccW'(HblankEnd)) begin
            res.draw_line  = 1'b1;
            res.drawn_line = state_i.line;
            nxt.accum      = rem_hb;
            nxt.line       = line_inc;
            if (line_inc == FirstVblankLine) begin
              nxt.mode       = MODE_VBLANK;
              res.vblank_irq = 1'b1;
            end else begin
              nxt.mode = MODE_SEARCH;
            end
            nxt.coin        = (line_inc == line_compare_i);
            res.compare_irq = (line_inc == line_compare_i);
          end
        end
        MODE_VBLANK: begin
          if (vbl_adv) begin
            nxt.line = line_inc;
            if (line_inc > LastLine) begin
              nxt.accum      = rem_fr;
              nxt.mode       = MODE_SEARCH;
              nxt.line       = '0;
              res.frame_done = 1'b1;
            end
          end
        end
        MODE_SEARCH: begin
          if (acc > AccW'(SearchEnd)) begin
            res.sprite_scan = 1'b1;
            nxt.accum       = rem_sr;
            nxt.mode        = MODE_TRANSFER;
          end
        end
        MODE_TRANSFER: begin
          if (acc > AccW'(TransferEnd)) begin
            res.tile_decode = 1'b1;
            nxt.accum       = rem_tr;
            nxt.mode        = MODE_HBLANK;
          end
        end
        default: begin
          nxt = state_i;
        end
      endcase
    end else begin
      nxt.accum = '0;
      nxt.line  = '0;
    end
    res.mode        = nxt.mode;
    res.line        = nxt.line;
    res.coincidence = nxt.coin;
  end

  assign state_o  = nxt;
  assign result_o = res;

endmodule

`default_nettype wire

FILE: rtl/lcd_mode_line_timing_top.sv
`timescale 1ns / 1ps
`default_nettype none

// LCD mode and line timing sequencer. Every request carries the machine cycles
// elapsed since the previous one and yields exactly one result, registered and
// presented in the cycle after the request is accepted. A request is taken in
// every cycle in which the result register is empty or being read in the same
// cycle, so the sustained rate is one request per clock while results are read;
// the timing state updates in one pass of a saturating add, a mode-threshold
// compare and a reciprocal-multiply modulo unit. Registers lcd_enable (index
// 0, reset 1) and line_compare (index 1, reset 0) are written through the cfg
// port by the user only while no request is in flight; the block does not check.

module lcd_mode_line_timing_top
  import lcdt_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_addr_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i,
  lcdt_req_if.sink            req_i,
  lcdt_rsp_if.source          rsp_o
);

  logic              cfg_enable_q;
  logic [LineW-1:0]  cfg_compare_q;
  state_t            state_q;
  state_t            state_d;
  result_t           result_q;
  result_t           result_d;
  logic              rsp_valid_q;
  logic              req_fire;

  assign req_i.ready = !rsp_valid_q || rsp_o.ready;
  assign req_fire    = req_i.valid && req_i.ready;

  lcdt_step u_step (
    .state_i        (state_q),
    .enable_i       (cfg_enable_q),
    .line_compare_i (cfg_compare_q),
    .cycles_i       (req_i.elapsed_cycles),
    .state_o        (state_d),
    .result_o       (result_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_enable_q  <= 1'b1;
      cfg_compare_q <= '0;
    end else if (cfg_we_i) begin
      case (reg_idx_e'(cfg_addr_i))
        REG_LCD_ENABLE:   cfg_enable_q  <= cfg_wdata_i[0];
        REG_LINE_COMPARE: cfg_compare_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q.mode  <= MODE_VBLANK;
      state_q.line  <= '0;
      state_q.accum <= '0;
      state_q.coin  <= 1'b0;
      rsp_valid_q   <= 1'b0;
    end else begin
      if (req_fire) begin
        state_q     <= state_d;
        rsp_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        rsp_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_fire) begin
      result_q <= result_d;
    end
  end

  assign rsp_o.valid       = rsp_valid_q;
  assign rsp_o.mode        = result_q.mode;
  assign rsp_o.line        = result_q.line;
  assign rsp_o.coincidence = result_q.coincidence;
  assign rsp_o.vblank_irq  = result_q.vblank_irq;
  assign rsp_o.compare_irq = result_q.compare_irq;
  assign rsp_o.draw_line   = result_q.draw_line;
  assign rsp_o.drawn_line  = result_q.drawn_line;
  assign rsp_o.sprite_scan = result_q.sprite_scan;
  assign rsp_o.tile_decode = result_q.tile_decode;
  assign rsp_o.frame_done  = result_q.frame_done;

  // a request taken while disabled leaves line zero and gives no pulses
  a_disabled_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_fire && !cfg_enable_q) |=>
      (rsp_o.valid && rsp_o.line == '0 && !rsp_o.draw_line && !rsp_o.frame_done &&
       !rsp_o.sprite_scan && !rsp_o.tile_decode))
    else $error("disabled request produced activity");

  a_vblank_entry: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_o.valid && rsp_o.vblank_irq) |->
      (rsp_o.draw_line && rsp_o.line == FirstVblankLine && rsp_o.mode == MODE_VBLANK))
    else $error("vblank request without entry into vblank");

  a_frame_wrap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_o.valid && rsp_o.frame_done) |->
      (rsp_o.line == '0 && rsp_o.mode == MODE_SEARCH))
    else $error("frame end without wrap to line zero");

  a_one_event: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.valid |->
      $onehot0({rsp_o.sprite_scan, rsp_o.tile_decode, rsp_o.draw_line, rsp_o.frame_done}))
    else $error("more than one mode transition in one result");

endmodule

`default_nettype wire

FILE: tb/tb_lcd_mode_line_timing_top.sv
`timescale 1ns / 1ps

module tb_lcd_mode_line_timing_top
  import lcdt_pkg::*;
();

  localparam int unsigned RandomItems = 1700;

  logic                clk_i     = 1'b0;
  logic                rst_ni    = 1'b0;
  logic                cfg_we    = 1'b0;
  logic [CfgIdxW-1:0]  cfg_addr  = '0;
  logic [CfgDataW-1:0] cfg_wdata = '0;
  logic                drv_valid = 1'b0;
  logic [CycW-1:0]     drv_cycles = '0;
  logic                mon_ready = 1'b0;

  lcdt_req_if req_if ();
  lcdt_rsp_if rsp_if ();

  assign req_if.valid          = drv_valid;
  assign req_if.elapsed_cycles = drv_cycles;
  assign rsp_if.ready          = mon_ready;

  lcd_mode_line_timing_top uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_addr_i  (cfg_addr),
    .cfg_wdata_i (cfg_wdata),
    .req_i       (req_if),
    .rsp_o       (rsp_if)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // timing state as the block should hold it
  logic             lcd_on   = 1'b1;
  logic [7:0]       cmp_line = '0;
  mode_e            tm_mode  = MODE_VBLANK;
  logic [LineW-1:0] tm_line  = '0;
  logic [AccW-1:0]  tm_accum = '0;
  logic             tm_coin  = 1'b0;

  logic [CycW-1:0] cycle_reqs[$];
  result_t         timing_results[$];

  int unsigned items_queued    = 0;
  int unsigned items_taken     = 0;
  int unsigned results_checked = 0;
  int unsigned errors          = 0;
  int unsigned frames          = 0;
  int unsigned compare_hits    = 0;
  int unsigned held_steps      = 0;
  int unsigned phase           = 0;
  int          wait_left       = 0;
  int          stall_left      = 0;
  bit          bursty          = 1'b0;

  function automatic result_t advance_timing(logic [CycW-1:0] cyc);
    result_t     r;
    int unsigned sum;
    r = '0;
    if (lcd_on) begin
      sum = int'(tm_accum) + int'(cyc);
      if (sum > 65535) sum = 65535;
      case (tm_mode)
        MODE_HBLANK: begin
          if (sum > HblankEnd) begin
            r.draw_line  = 1'b1;
            r.drawn_line = tm_line;
            sum          = sum % HblankEnd;
            tm_line      = tm_line + 8'd1;
            if (tm_line == FirstVblankLine) begin
              tm_mode      = MODE_VBLANK;
              r.vblank_irq = 1'b1;
            end else begin
              tm_mode = MODE_SEARCH;
            end
            if (tm_line == cmp_line) begin
              tm_coin       = 1'b1;
              r.compare_irq = 1'b1;
              compare_hits++;
            end else begin
              tm_coin = 1'b0;
            end
          end
        end
        MODE_VBLANK: begin
          // one vblank line per step at most, even when far behind
          if (sum / int'(VblankLine) + int'(FirstVblankLine) > int'(tm_line)) begin
            tm_line = tm_line + 8'd1;
            if (tm_line > LastLine) begin
              sum          = sum % FrameCycles;
              tm_mode      = MODE_SEARCH;
              tm_line      = '0;
              r.frame_done = 1'b1;
              frames++;
            end
          end
        end
        MODE_SEARCH: begin
          if (sum > SearchEnd) begin
            r.sprite_scan = 1'b1;
            sum           = sum % SearchEnd;
            tm_mode       = MODE_TRANSFER;
          end
        end
        default: begin
          if (sum > TransferEnd) begin
            sum           = sum % TransferEnd;
            tm_mode       = MODE_HBLANK;
            r.tile_decode = 1'b1;
          end
        end
      endcase
      tm_accum = sum[AccW-1:0];
    end else begin
      tm_accum = '0;
      tm_line  = '0;
      held_steps++;
    end
    r.mode        = tm_mode;
    r.line        = tm_line;
    r.coincidence = tm_coin;
    return r;
  endfunction

  task automatic check_field(string name, int want, int got);
    if (want != got) begin
      errors++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    end
  endtask

  task automatic check_result(result_t want);
    check_field("mode", want.mode, rsp_if.mode);
    check_field("line", want.line, rsp_if.line);
    check_field("coincidence", want.coincidence, rsp_if.coincidence);
    check_field("vblank_irq", want.vblank_irq, rsp_if.vblank_irq);
    check_field("compare_irq", want.compare_irq, rsp_if.compare_irq);
    check_field("draw_line", want.draw_line, rsp_if.draw_line);
    check_field("drawn_line", want.drawn_line, rsp_if.drawn_line);
    check_field("sprite_scan", want.sprite_scan, rsp_if.sprite_scan);
    check_field("tile_decode", want.tile_decode, rsp_if.tile_decode);
    check_field("frame_done", want.frame_done, rsp_if.frame_done);
    results_checked++;
  endtask

  // request driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      drv_valid  <= 1'b0;
      drv_cycles <= '0;
      wait_left  = 0;
    end else begin
      if (drv_valid && req_if.ready) begin
        timing_results = {timing_results, advance_timing(drv_cycles)};
        items_taken++;
        wait_left = bursty ? 0 : $urandom_range(0, 19);
      end
      if (!drv_valid || req_if.ready) begin
        if (wait_left > 0) begin
          wait_left--;
          drv_valid <= 1'b0;
        end else if (cycle_reqs.size() != 0) begin
          drv_valid  <= 1'b1;
          drv_cycles <= cycle_reqs.pop_front();
        end else begin
          drv_valid <= 1'b0;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mon_ready  <= 1'b0;
      stall_left = 0;
    end else begin
      if (rsp_if.valid && mon_ready) begin
        if (timing_results.size() == 0) begin
          errors++;
          $display("%0t: result with none expected, expected nothing, actual mode %0d line %0d",
                   $time, rsp_if.mode, rsp_if.line);
        end else begin
          check_result(timing_results.pop_front());
        end
        stall_left = bursty ? 0 : $urandom_range(0, 19);
      end
      if (stall_left > 0) begin
        stall_left--;
        mon_ready <= 1'b0;
      end else begin
        mon_ready <= 1'b1;
      end
    end
  end

  task automatic queue_item(logic [CycW-1:0] v);
    cycle_reqs = {cycle_reqs, v};
    items_queued++;
  endtask

  task automatic wait_idle();
    while (items_taken != items_queued || timing_results.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_reg(reg_idx_e idx, logic [CfgDataW-1:0] val);
    @(posedge clk_i);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= val;
    @(posedge clk_i);
    cfg_we <= 1'b0;
    if (idx == REG_LCD_ENABLE) lcd_on = val[0];
    else cmp_line = val;
  endtask

  // mostly large steps so that frames wrap often, some tiny ones for slow crawls
  function automatic logic [CycW-1:0] pick_cycles();
    case ($urandom_range(0, 9))
      0, 1:    return CycW'($urandom_range(0, 15));
      2, 3, 4: return CycW'($urandom_range(0, 255));
      default: return CycW'($urandom_range(160, 255));
    endcase
  endfunction

  initial begin
    logic [CycW-1:0] directed [16];
    logic [7:0]      target;
    int unsigned     base;
    int unsigned     n;
    directed = '{8'd0, 8'd255, 8'd1, 8'd2, 8'd4, 8'd8, 8'd16, 8'd32,
                 8'd64, 8'd128, 8'hAA, 8'h55, 8'd254, 8'd127, 8'd0, 8'd255};
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset values of both registers, vblank walk from line 0
    foreach (directed[i]) queue_item(directed[i]);
    wait_idle();

    // display off: line and count held at zero, mode held, no pulses
    write_reg(REG_LCD_ENABLE, 8'd0);
    queue_item(8'd0);
    queue_item(8'd255);
    queue_item(8'd37);
    queue_item(8'd200);
    wait_idle();

    // back on while in vblank at a low line
    write_reg(REG_LINE_COMPARE, 8'd255);
    write_reg(REG_LCD_ENABLE, 8'd1);
    repeat (6) queue_item(CycW'($urandom_range(0, 255)));
    wait_idle();

    base = items_queued;
    while (items_queued - base < RandomItems) begin
      case (phase % 6)
        0, 5: target = 8'((tm_line < 120) ? tm_line + $urandom_range(1, 20)
                                          : $urandom_range(1, 143));
        1:    target = 8'd144;
        2:    target = 8'd255;
        3:    target = 8'd0;
        default: target = 8'($urandom_range(0, 255));
      endcase
      write_reg(REG_LINE_COMPARE, target);
      bursty = (phase % 3 == 2);
      n = $urandom_range(150, 260);
      repeat (n) queue_item(pick_cycles());
      wait_idle();
      if (phase % 4 == 3) begin
        // switch off mid-frame, the mode and flag must stay put
        write_reg(REG_LCD_ENABLE, 8'd0);
        repeat (6) queue_item(CycW'($urandom_range(0, 255)));
        wait_idle();
        write_reg(REG_LCD_ENABLE, 8'd1);
      end
      phase++;
    end
    bursty = 1'b0;

    wait_idle();
    repeat (5) @(posedge clk_i);
    $display("run covered %0d requests in %0d phases: %0d frames wrapped, %0d line-compare hits",
             items_taken, phase, frames, compare_hits);
    $display("%0d results checked, %0d requests taken with the display off",
             results_checked, held_steps);
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin
    #(5_000_000);
    $display("TEST FAILED");
    $finish;
  end

endmodule
